>>> rtl/fosl_pkg.sv
// Shared types and constants for the frequency-ordered search list.
// No dependencies; imported by the control sequencer and the top level.

package fosl_pkg;

	// request type codes
	localparam logic REQ_SEARCH = 1'b0;
	localparam logic REQ_LOAD   = 1'b1;

	// list length after reset
	localparam logic [4:0] LIST_LENGTH_RESET = 5'd16;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT,
		ST_PLACE
	} state_t;

	// one result as delivered on the result ports
	typedef struct packed {
		logic        hit;
		logic [3:0]  old_position;
		logic [3:0]  new_position;
		logic [15:0] hit_count;
	} result_t;

endpackage

>>> rtl/fosl_store.sv
// Entry store: one write port, one read port with registered read data.
// Generic RAM, no dependencies; each word packs an entry value and its hit count.

module fosl_store #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 48
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write one entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// register the read data
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/fosl_ctrl.sv
// Sequencer for the frequency-ordered search list: scan, shift toward front, place.
// Depends on fosl_pkg; drives one fosl_store instance through its ports.

module fosl_ctrl import fosl_pkg::*; #(
	parameter int MAX_ENTRIES = 16,
	parameter int VALUE_WIDTH = 32,
	parameter int COUNT_WIDTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic                               req_type,
	input  logic [31:0]                        key_value,
	input  logic [3:0]                         load_slot,
	input  logic [4:0]                         list_length,
	output logic                               busy,
	output logic                               done,
	output result_t                            result,
	output logic                               mem_we,
	output logic [$clog2(MAX_ENTRIES)-1:0]     mem_waddr,
	output logic [VALUE_WIDTH+COUNT_WIDTH-1:0] mem_wdata,
	output logic [$clog2(MAX_ENTRIES)-1:0]     mem_raddr,
	input  logic [VALUE_WIDTH+COUNT_WIDTH-1:0] mem_rdata
);

	localparam int IDX_W  = $clog2(MAX_ENTRIES);
	localparam int USED_W = IDX_W + 1;

	state_t                 state_q, state_d;
	logic                   done_q, done_d;
	result_t                res_q, res_d;
	logic [IDX_W-1:0]       idx_q, idx_d;
	logic [IDX_W-1:0]       pos_q, pos_d;
	logic [VALUE_WIDTH-1:0] key_q, key_d;
	logic [VALUE_WIDTH-1:0] val_q, val_d;
	logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;

	logic [USED_W-1:0]      used;
	logic [USED_W-1:0]      idx_p1;
	logic [IDX_W-1:0]       pos_m1;
	logic [VALUE_WIDTH-1:0] rd_val;
	logic [COUNT_WIDTH-1:0] rd_cnt;
	logic [COUNT_WIDTH-1:0] rd_cnt_inc;
	logic                   key_eq;
	logic                   cnt_ge;
	logic                   slot_ok;

	// clamp the list length to the store depth
	always_comb begin
		if (32'(list_length) > MAX_ENTRIES) begin
			used = USED_W'(MAX_ENTRIES);
		end else begin
			used = USED_W'(list_length);
		end
	end

	// shared compare and increment unit on the read word
	assign rd_val     = mem_rdata[VALUE_WIDTH+COUNT_WIDTH-1:COUNT_WIDTH];
	assign rd_cnt     = mem_rdata[COUNT_WIDTH-1:0];
	assign key_eq     = (rd_val == key_q);
	assign cnt_ge     = (cnt_q >= rd_cnt);
	assign rd_cnt_inc = (rd_cnt == '1) ? rd_cnt : rd_cnt + COUNT_WIDTH'(1);

	assign idx_p1  = {1'b0, idx_q} + USED_W'(1);
	assign pos_m1  = pos_q - IDX_W'(1);
	assign slot_ok = (32'(load_slot) < MAX_ENTRIES);

	// next state, memory controls and result
	always_comb begin
		state_d   = state_q;
		done_d    = 1'b0;
		res_d     = res_q;
		idx_d     = idx_q;
		pos_d     = pos_q;
		key_d     = key_q;
		val_d     = val_q;
		cnt_d     = cnt_q;
		mem_we    = 1'b0;
		mem_waddr = pos_q;
		mem_wdata = {val_q, cnt_q};
		mem_raddr = '0;

		case (state_q)
			ST_IDLE: begin
				if (start) begin
					key_d = VALUE_WIDTH'(key_value);
					if (req_type == REQ_LOAD) begin
						// write value, clear count, answer with a zero result
						mem_we    = slot_ok;
						mem_waddr = IDX_W'(load_slot);
						mem_wdata = {VALUE_WIDTH'(key_value), COUNT_WIDTH'(0)};
						done_d    = 1'b1;
						res_d     = '0;
					end else if (used == '0) begin
						done_d = 1'b1;
						res_d  = '0;
					end else begin
						mem_raddr = '0;
						idx_d     = '0;
						state_d   = ST_SCAN;
					end
				end
			end

			ST_SCAN: begin
				if (key_eq) begin
					val_d = rd_val;
					cnt_d = rd_cnt_inc;
					pos_d = idx_q;
					if (idx_q == '0) begin
						state_d = ST_PLACE;
					end else begin
						mem_raddr = idx_q - IDX_W'(1);
						state_d   = ST_SHIFT;
					end
				end else if (idx_p1 >= used) begin
					// drop: no entry matched
					done_d  = 1'b1;
					res_d   = '0;
					state_d = ST_IDLE;
				end else begin
					mem_raddr = IDX_W'(idx_p1);
					idx_d     = IDX_W'(idx_p1);
				end
			end

			ST_SHIFT: begin
				// read data holds the entry just in front of pos
				if (cnt_ge) begin
					mem_we    = 1'b1;
					mem_waddr = pos_q;
					mem_wdata = mem_rdata;
					pos_d     = pos_m1;
					if (pos_m1 != '0) begin
						mem_raddr = pos_m1 - IDX_W'(1);
					end else begin
						state_d = ST_PLACE;
					end
				end else begin
					state_d = ST_PLACE;
				end
			end

			ST_PLACE: begin
				mem_we                = 1'b1;
				mem_waddr             = pos_q;
				mem_wdata             = {val_q, cnt_q};
				done_d                = 1'b1;
				res_d.hit             = 1'b1;
				res_d.old_position    = 4'(idx_q);
				res_d.new_position    = 4'(pos_q);
				res_d.hit_count       = 16'(cnt_q);
				state_d               = ST_IDLE;
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		res_q <= res_d;
		idx_q <= idx_d;
		pos_q <= pos_d;
		key_q <= key_d;
		val_q <= val_d;
		cnt_q <= cnt_d;
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = res_q;

endmodule

>>> rtl/frequency_ordered_search_list.sv
// Top level of the frequency-ordered search list (count method).
// Depends on fosl_pkg, fosl_store and fosl_ctrl.
//
//   channel   handshake                 payload
//   request   start, busy               req_type, key_value, load_slot
//   result    done (one-cycle strobe)   hit, old_position, new_position, hit_count
//   config    cfg_valid, cfg_ready      cfg_data (list_length)
//
// A load writes its slot when accepted; its zero result strobes in the next cycle.
// A search scans from slot 0 until the key matches, then moves the hit entry toward
// the front past every entry whose hit count does not exceed its incremented count,
// stopping at slot 0 or at a larger count, and places it there; a miss scans
// min(list_length, 16) entries; the single read port gives one entry per cycle.
// Reset clears the sequencer and sets list_length to 16; stored entries are not cleared.
// The receiver cannot stall: each result is valid for the one cycle done is high.

module frequency_ordered_search_list import fosl_pkg::*; #(
	parameter int MAX_ENTRIES = 16,
	parameter int VALUE_WIDTH = 32,
	parameter int COUNT_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        req_type,
	input  logic [31:0] key_value,
	input  logic [3:0]  load_slot,
	output logic        done,
	output logic        hit,
	output logic [3:0]  old_position,
	output logic [3:0]  new_position,
	output logic [15:0] hit_count,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data
);

	localparam int IDX_W  = $clog2(MAX_ENTRIES);
	localparam int WORD_W = VALUE_WIDTH + COUNT_WIDTH;

	logic [4:0]        length_q;
	result_t           result;
	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr;
	logic [WORD_W-1:0] mem_wdata;
	logic [IDX_W-1:0]  mem_raddr;
	logic [WORD_W-1:0] mem_rdata;

	// hold the list length register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q <= LIST_LENGTH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			length_q <= cfg_data;
		end
	end

	fosl_ctrl #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.VALUE_WIDTH (VALUE_WIDTH),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.req_type    (req_type),
		.key_value   (key_value),
		.load_slot   (load_slot),
		.list_length (length_q),
		.busy        (busy),
		.done        (done),
		.result      (result),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_raddr   (mem_raddr),
		.mem_rdata   (mem_rdata)
	);

	fosl_store #(
		.DEPTH (MAX_ENTRIES),
		.WIDTH (WORD_W)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// drive the result ports
	assign hit          = result.hit;
	assign old_position = result.old_position;
	assign new_position = result.new_position;
	assign hit_count    = result.hit_count;

	// a finished search always strobes its result as the sequencer goes idle
	a_done_on_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("search finished without a result strobe");

	// a load answers in the next cycle and leaves the block free
	a_load_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req_type == REQ_LOAD) |=> (done && !busy && !hit))
		else $error("load did not answer in one cycle");

	// starting a scan produces no result in the same cycle
	a_no_result_on_scan: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> !done)
		else $error("result strobe while a scan starts");

endmodule
